### hw/rtl/llrw_pkg.sv
package llrw_pkg;

	typedef enum logic [1:0] {
		KIND_POLL  = 2'd0,
		KIND_ENDED = 2'd1,
		KIND_ARM   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_ENABLE          = 2'd0,
		REG_WAIT_MS         = 2'd1,
		REG_COOLDOWN_MS     = 2'd2,
		REG_REQ_TIMEOUT_MS  = 2'd3
	} reg_idx_t;

	localparam int unsigned TimeW = 32;

	localparam logic [TimeW-1:0] WaitMsReset       = 32'd40000;
	localparam logic [TimeW-1:0] CooldownMsReset   = 32'd60000;
	localparam logic [TimeW-1:0] ReqTimeoutMsReset = 32'd10000;

	typedef struct packed {
		kind_t            kind;
		logic [TimeW-1:0] now_ms;
		logic             link_up;
		logic             launcher_ready;
	} in_t;

	typedef struct packed {
		logic start_request;
		logic abort_request;
		logic request_in_flight;
		logic outage_timing;
	} out_t;

	typedef struct packed {
		logic             enable;
		logic [TimeW-1:0] wait_ms;
		logic [TimeW-1:0] cooldown_ms;
		logic [TimeW-1:0] request_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic             outage_running;
		logic [TimeW-1:0] outage_start;
		logic [TimeW-1:0] last_trigger_time;
		logic             has_triggered;
		logic             pending;
		logic [TimeW-1:0] request_start;
	} state_t;

endpackage

### hw/rtl/llrw_step.sv
module llrw_step (
	input  llrw_pkg::in_t    item,
	input  llrw_pkg::cfg_t   cfg,
	input  llrw_pkg::state_t state,
	output llrw_pkg::state_t state_nxt,
	output llrw_pkg::out_t   result
);

	logic [llrw_pkg::TimeW-1:0] req_age;
	logic [llrw_pkg::TimeW-1:0] outage_age;
	logic [llrw_pkg::TimeW-1:0] trig_age;
	logic                       timed_out;
	logic                       in_cooldown;
	logic                       started;
	logic                       aborted;

	// all ages wrap modulo 2^32
	assign req_age     = item.now_ms - state.request_start;
	assign outage_age  = item.now_ms - state.outage_start;
	assign trig_age    = item.now_ms - state.last_trigger_time;
	assign timed_out   = state.pending && (req_age > cfg.request_timeout_ms);
	assign in_cooldown = state.has_triggered && (trig_age < cfg.cooldown_ms);

	always_comb begin
		state_nxt = state;
		started   = 1'b0;
		aborted   = 1'b0;
		unique case (item.kind)
			llrw_pkg::KIND_ENDED: begin
				state_nxt.pending = 1'b0;
			end
			llrw_pkg::KIND_ARM: begin
				if (cfg.enable) begin
					state_nxt.outage_running    = 1'b1;
					state_nxt.outage_start      = item.now_ms;
					state_nxt.last_trigger_time = '0;
					state_nxt.request_start     = '0;
					state_nxt.has_triggered     = 1'b0;
					state_nxt.pending           = 1'b0;
				end
			end
			llrw_pkg::KIND_POLL: begin
				if (cfg.enable) begin
					if (timed_out) begin
						state_nxt.pending = 1'b0;
						aborted           = 1'b1;
					end
					if (item.link_up) begin
						state_nxt.outage_running = 1'b0;
					end else if (!state.outage_running) begin
						state_nxt.outage_running = 1'b1;
						state_nxt.outage_start   = item.now_ms;
					end else if (outage_age >= cfg.wait_ms && !state_nxt.pending &&
							!in_cooldown && item.launcher_ready) begin
						state_nxt.pending           = 1'b1;
						state_nxt.request_start     = item.now_ms;
						state_nxt.last_trigger_time = item.now_ms;
						state_nxt.has_triggered     = 1'b1;
						state_nxt.outage_start      = item.now_ms;
						started                     = 1'b1;
					end
				end
			end
			default: begin
				// undefined kind: state held, status reported
			end
		endcase
	end

	assign result.start_request     = started;
	assign result.abort_request     = aborted;
	assign result.request_in_flight = state_nxt.pending;
	assign result.outage_timing     = state_nxt.outage_running;

endmodule

### hw/rtl/link_loss_recovery_watchdog.sv
// An input transaction passes the input register, then the result register; one
// transaction per cycle unless out_ready stalls. The state update is a single pass of
// three wrapping 32-bit subtract-and-compare paths between the two registers.
// Reset (arst_n low, asynchronous): both stages empty, watchdog disabled,
// wait/cooldown/timeout at 40000/60000/10000 ms, all timer state cleared.
module link_loss_recovery_watchdog (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  llrw_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output llrw_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	logic             valid_s1;
	llrw_pkg::in_t    item_s1;
	logic             out_valid_q;
	llrw_pkg::out_t   out_q;
	llrw_pkg::cfg_t   cfg_q;
	llrw_pkg::state_t state_q;
	llrw_pkg::state_t state_nxt;
	llrw_pkg::out_t   result;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	llrw_step u_step (
		.item      (item_s1),
		.cfg       (cfg_q),
		.state     (state_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable             <= 1'b0;
			cfg_q.wait_ms            <= llrw_pkg::WaitMsReset;
			cfg_q.cooldown_ms        <= llrw_pkg::CooldownMsReset;
			cfg_q.request_timeout_ms <= llrw_pkg::ReqTimeoutMsReset;
		end else if (cfg_we) begin
			unique case (llrw_pkg::reg_idx_t'(cfg_index))
				llrw_pkg::REG_ENABLE:         cfg_q.enable             <= cfg_data[0];
				llrw_pkg::REG_WAIT_MS:        cfg_q.wait_ms            <= cfg_data;
				llrw_pkg::REG_COOLDOWN_MS:    cfg_q.cooldown_ms        <= cfg_data;
				llrw_pkg::REG_REQ_TIMEOUT_MS: cfg_q.request_timeout_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// a launched request is always in flight and restarts the outage timer
	a_start_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.start_request |->
			out_data.request_in_flight && out_data.outage_timing)
		else $error("start_request without pending request or running timer");

	// pending only rises through a start, reported by the transaction just loaded
	a_pending_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.pending) |-> out_valid && out_data.start_request)
		else $error("pending set without start_request");

	// state moves only when a transaction passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(state_q))
		else $error("watchdog state changed without a transaction");
`endif

endmodule
